### hdl/sbsm_pkg.sv
// Shared constants, item types and controller/datapath signal groups for the stack machine.
package sbsm_pkg;

  // Storage sizes.
  localparam int MEM_DEPTH   = 32768;
  localparam int STACK_DEPTH = 256;
  localparam int INPUT_DEPTH = 32;

  localparam int PM_AW  = $clog2(MEM_DEPTH);
  localparam int SI_W   = $clog2(STACK_DEPTH);
  localparam int SP_W   = SI_W + 1;
  localparam int IB_W   = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int CUR_W  = IB_W + 1;
  localparam int ADDR_W = 15;
  localparam int IP_W   = 16;
  localparam int WORD_W = 16;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 1;

  // Highest address plus one that a fetch or a jump may use.
  localparam int MEM_LIMIT = (MEM_DEPTH < 32768) ? MEM_DEPTH : 32768;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS  = 1'd1;
  localparam logic [ADDR_W-1:0]    ORIGIN_RST = 15'h3000;
  localparam logic [CFG_W-1:0]     STEPS_RST  = 32'd1000000;

  // Input item kinds.
  localparam logic [1:0] LD_PROG  = 2'd0;
  localparam logic [1:0] LD_INPUT = 2'd1;
  localparam logic [1:0] LD_RUN   = 2'd2;

  // Instruction opcodes.
  localparam logic [7:0] OPC_HALT = 8'd225;
  localparam logic [7:0] OPC_PUSH = 8'd164;
  localparam logic [7:0] OPC_POP  = 8'd155;
  localparam logic [7:0] OPC_XOR  = 8'd3;
  localparam logic [7:0] OPC_MUL  = 8'd162;
  localparam logic [7:0] OPC_INP  = 8'd177;
  localparam logic [7:0] OPC_JZ   = 8'd82;
  localparam logic [7:0] OPC_DUP  = 8'd206;
  localparam logic [7:0] OPC_INC  = 8'd102;
  localparam logic [7:0] OPC_JEMP = 8'd223;

  // Run status codes.
  localparam logic [2:0] ST_HALT  = 3'd0;
  localparam logic [2:0] ST_BADOP = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_INPUT = 3'd4;
  localparam logic [2:0] ST_ADDR  = 3'd5;
  localparam logic [2:0] ST_STEPS = 3'd6;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [4:0]        input_index;
    logic [7:0]        data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] halt_value;
    logic [2:0]               status;
    logic [ADDR_W-1:0]        final_address;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr_wr;
    logic       load_wr;
    logic       run_init;
    logic       fetch;
    logic       op_latch;
    logic       imlo;
    logic       imhi;
    logic       rd_top;
    logic       rd_sec;
    logic       exec;
    logic       finish;
    logic [2:0] fin_status;
    logic       out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clr_last;
    logic       steps_hit;
    logic       ip_bad;
    logic       needs_imm;
    logic       imm_bad;
    logic       exec_end;
    logic [2:0] exec_status;
  } dp_stat_t;

endpackage

### hdl/sbsm_in_if.sv
// Input channel: valid/ready handshake carrying one load or run item.
interface sbsm_in_if import sbsm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/sbsm_out_if.sv
// Result channel: valid/ready handshake carrying one run result item.
interface sbsm_out_if import sbsm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/sbsm_ctrl.sv
// Controller state machine: sequences memory clearing, loads and instruction execution.
module sbsm_ctrl import sbsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_OPC   = 10'b0000001000,
    S_IMLO  = 10'b0000010000,
    S_IMHI  = 10'b0000100000,
    S_RDTOP = 10'b0001000000,
    S_RDSEC = 10'b0010000000,
    S_EXEC  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.fin_status = ST_HALT;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (in_opcode == LD_RUN) begin
            cmd.run_init = 1'b1;
            state_nxt    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (stat.steps_hit) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_STEPS;
          state_nxt      = S_DONE;
        end else if (stat.ip_bad) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_ADDR;
          state_nxt      = S_DONE;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_OPC;
        end
      end
      S_OPC: begin
        cmd.op_latch = 1'b1;
        if (stat.needs_imm) begin
          if (stat.imm_bad) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_ADDR;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_IMLO;
          end
        end else begin
          state_nxt = S_RDTOP;
        end
      end
      S_IMLO: begin
        cmd.imlo  = 1'b1;
        state_nxt = S_IMHI;
      end
      S_IMHI: begin
        cmd.imhi  = 1'b1;
        state_nxt = S_RDTOP;
      end
      S_RDTOP: begin
        cmd.rd_top = 1'b1;
        state_nxt  = S_RDSEC;
      end
      S_RDSEC: begin
        cmd.rd_sec = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.exec_end) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = stat.exec_status;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_DONE: begin
        // Move the finished result into the output register once it is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/sbsm_dp.sv
// Datapath: program memory, operand stack, input buffer, machine registers and results.
module sbsm_dp import sbsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output out_item_t            out_item
);

  logic [ADDR_W-1:0] origin_r;
  logic [CFG_W-1:0]  limit_r;
  logic [IP_W-1:0]   ip_r;
  logic [SP_W-1:0]   sp_r;
  logic [CUR_W-1:0]  cur_r;
  logic [CFG_W-1:0]  steps_r;
  logic [7:0]        op_r;
  logic [WORD_W-1:0] imm_r;
  logic [WORD_W-1:0] top_r;
  logic [PM_AW-1:0]  clr_addr_r;
  out_item_t         pend_r;
  out_item_t         out_r;

  logic [7:0]        pmem [MEM_DEPTH];
  logic [7:0]        pm_rd_r;
  logic [WORD_W-1:0] stk [STACK_DEPTH];
  logic [WORD_W-1:0] st_rd_r;
  logic [7:0]        ib_r [INPUT_DEPTH];

  logic              pm_we;
  logic [PM_AW-1:0]  pm_wa, pm_ra;
  logic [7:0]        pm_wd;
  logic [SI_W-1:0]   st_ra;
  logic [IP_W-1:0]   ip_p1, ip_p2, ip_p3;
  logic              ib_we;

  // Exec results.
  logic              ex_end;
  logic [2:0]        ex_status;
  logic [IP_W-1:0]   ip_n;
  logic [SP_W-1:0]   sp_n;
  logic              cur_inc;
  logic              st_we;
  logic [SI_W-1:0]   st_wa;
  logic [WORD_W-1:0] st_wd;
  logic [31:0]       prod;
  logic [WORD_W-1:0] inp_word;
  logic              sp_zero, sp_lt2, sp_full, cur_out, imm_ok;

  assign ip_p1 = ip_r + IP_W'(1);
  assign ip_p2 = ip_r + IP_W'(2);
  assign ip_p3 = ip_r + IP_W'(3);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= ORIGIN_RST;
      limit_r  <= STEPS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ORIGIN) begin
        origin_r <= cfg_wdata[ADDR_W-1:0];
      end else if (cfg_index == CFG_STEPS) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Program memory: one write port shared by clearing and loads, one read port.
  assign pm_we = cmd.clr_wr ||
                 (cmd.load_wr && in_item.opcode == LD_PROG &&
                  {2'b0, in_item.address} < 17'(MEM_DEPTH));
  assign pm_wa = cmd.clr_wr ? clr_addr_r : in_item.address[PM_AW-1:0];
  assign pm_wd = cmd.clr_wr ? 8'd0 : in_item.data_byte;
  always_comb begin
    if (cmd.fetch) begin
      pm_ra = ip_r[PM_AW-1:0];
    end else if (cmd.op_latch) begin
      pm_ra = ip_p1[PM_AW-1:0];
    end else begin
      pm_ra = ip_p2[PM_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_wa] <= pm_wd;
    end
    pm_rd_r <= pmem[pm_ra];
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + PM_AW'(1);
    end
  end

  // Input character buffer.
  assign ib_we = cmd.load_wr && in_item.opcode == LD_INPUT &&
                 {1'b0, in_item.input_index} < 6'(INPUT_DEPTH);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < INPUT_DEPTH; i++) begin
        ib_r[i] <= '0;
      end
    end else if (ib_we) begin
      ib_r[in_item.input_index[IB_W-1:0]] <= in_item.data_byte;
    end
  end

  // Operand stack memory.
  assign st_ra = cmd.rd_top ? SI_W'(sp_r - SP_W'(1)) : SI_W'(sp_r - SP_W'(2));
  always_ff @(posedge clk) begin
    if (cmd.exec && !ex_end && st_we) begin
      stk[st_wa] <= st_wd;
    end
    st_rd_r <= stk[st_ra];
  end

  // Instruction execution.
  assign sp_zero  = (sp_r == '0);
  assign sp_lt2   = (sp_r < SP_W'(2));
  assign sp_full  = ({1'b0, sp_r} >= (SP_W+1)'(STACK_DEPTH));
  assign cur_out  = ({1'b0, cur_r} >= (CUR_W+1)'(INPUT_DEPTH));
  assign imm_ok   = {1'b0, imm_r} < 17'(MEM_LIMIT);
  assign prod     = top_r * st_rd_r;
  assign inp_word = {{8{ib_r[cur_r[IB_W-1:0]][7]}}, ib_r[cur_r[IB_W-1:0]]};

  always_comb begin
    ex_end    = 1'b0;
    ex_status = ST_HALT;
    ip_n      = ip_p1;
    sp_n      = sp_r;
    cur_inc   = 1'b0;
    st_we     = 1'b0;
    st_wa     = sp_r[SI_W-1:0];
    st_wd     = imm_r;
    unique case (op_r) inside
      OPC_HALT: begin
        ex_end = 1'b1;
      end
      OPC_PUSH: begin
        if (sp_full) begin
          ex_end    = 1'b1;
          ex_status = ST_OVER;
        end else begin
          st_we = 1'b1;
          sp_n  = sp_r + SP_W'(1);
          ip_n  = ip_p3;
        end
      end
      OPC_POP: begin
        if (sp_zero) begin
          ex_end    = 1'b1;
          ex_status = ST_UNDER;
        end else begin
          sp_n = sp_r - SP_W'(1);
        end
      end
      OPC_XOR, OPC_MUL: begin
        if (sp_lt2) begin
          ex_end    = 1'b1;
          ex_status = ST_UNDER;
        end else begin
          st_we = 1'b1;
          st_wa = SI_W'(sp_r - SP_W'(2));
          st_wd = (op_r == OPC_XOR) ? (top_r ^ st_rd_r) : prod[WORD_W-1:0];
          sp_n  = sp_r - SP_W'(1);
        end
      end
      OPC_INP: begin
        if (cur_out) begin
          ex_end    = 1'b1;
          ex_status = ST_INPUT;
        end else if (sp_full) begin
          ex_end    = 1'b1;
          ex_status = ST_OVER;
        end else begin
          st_we   = 1'b1;
          st_wd   = inp_word;
          sp_n    = sp_r + SP_W'(1);
          cur_inc = 1'b1;
        end
      end
      OPC_JZ: begin
        if (sp_zero) begin
          ex_end    = 1'b1;
          ex_status = ST_UNDER;
        end else begin
          sp_n = sp_r - SP_W'(1);
          if (top_r == '0) begin
            if (!imm_ok) begin
              ex_end    = 1'b1;
              ex_status = ST_ADDR;
            end else begin
              ip_n = imm_r;
            end
          end else begin
            ip_n = ip_p3;
          end
        end
      end
      OPC_DUP: begin
        if (sp_zero) begin
          ex_end    = 1'b1;
          ex_status = ST_UNDER;
        end else if (sp_full) begin
          ex_end    = 1'b1;
          ex_status = ST_OVER;
        end else begin
          st_we = 1'b1;
          st_wd = top_r;
          sp_n  = sp_r + SP_W'(1);
        end
      end
      OPC_INC: begin
        if (sp_zero) begin
          ex_end    = 1'b1;
          ex_status = ST_UNDER;
        end else begin
          st_we = 1'b1;
          st_wa = SI_W'(sp_r - SP_W'(1));
          st_wd = top_r + WORD_W'(1);
        end
      end
      OPC_JEMP: begin
        if (sp_zero) begin
          if (!imm_ok) begin
            ex_end    = 1'b1;
            ex_status = ST_ADDR;
          end else begin
            ip_n = imm_r;
          end
        end else begin
          ip_n = ip_p3;
        end
      end
      default: begin
        ex_end    = 1'b1;
        ex_status = ST_BADOP;
      end
    endcase
  end

  // Machine registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r    <= {1'b0, ORIGIN_RST};
      sp_r    <= '0;
      cur_r   <= '0;
      steps_r <= '0;
    end else if (cmd.run_init) begin
      ip_r    <= {1'b0, origin_r};
      sp_r    <= '0;
      cur_r   <= '0;
      steps_r <= '0;
    end else begin
      if (cmd.fetch) begin
        steps_r <= steps_r + CFG_W'(1);
      end
      if (cmd.exec && !ex_end) begin
        ip_r <= ip_n;
        sp_r <= sp_n;
        if (cur_inc) begin
          cur_r <= cur_r + CUR_W'(1);
        end
      end
    end
  end

  // Fetched opcode, immediate and top-of-stack operand.
  always_ff @(posedge clk) begin
    if (cmd.op_latch) begin
      op_r <= pm_rd_r;
    end
    if (cmd.imlo) begin
      imm_r[7:0] <= pm_rd_r;
    end
    if (cmd.imhi) begin
      imm_r[15:8] <= pm_rd_r;
    end
    if (cmd.rd_sec) begin
      top_r <= st_rd_r;
    end
  end

  // Pending result and output register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pend_r.status        <= cmd.fin_status;
      pend_r.halt_value    <= (cmd.fin_status == ST_HALT) ? imm_r : '0;
      pend_r.final_address <= ip_r[ADDR_W-1:0];
    end
    if (cmd.out_load) begin
      out_r <= pend_r;
    end
  end

  assign out_item = out_r;

  assign stat.clr_last    = (clr_addr_r == PM_AW'(MEM_DEPTH - 1));
  assign stat.steps_hit   = (steps_r >= limit_r);
  assign stat.ip_bad      = !({1'b0, ip_r} < 17'(MEM_LIMIT));
  assign stat.needs_imm   = (pm_rd_r == OPC_HALT) || (pm_rd_r == OPC_PUSH) ||
                            (pm_rd_r == OPC_JZ) || (pm_rd_r == OPC_JEMP);
  assign stat.imm_bad     = !({1'b0, ip_p2} < 17'(MEM_LIMIT));
  assign stat.exec_end    = ex_end;
  assign stat.exec_status = ex_status;

endmodule

### hdl/sixteen_bit_stack_machine.sv
// Top level of the byte-coded sixteen-bit stack machine.
// After reset the block clears program memory, one byte per cycle, and takes no
// item until that pass ends (configuration writes are taken). A program-byte or
// input-character item is written as it is taken. A run item steps each
// instruction through FETCH, OPC, RDTOP, RDSEC and EXEC, with IMLO and IMHI after
// OPC for one with an immediate (HALT, PUSH, JZ, JEMP), set by the single
// read port of program memory and the registered reads of the operand stack; the
// result then sits in an output register while further items are accepted.
module sixteen_bit_stack_machine import sbsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  sbsm_in_if.sink              in_chan,
  sbsm_out_if.source           out_chan
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t out_item;

  // Controller.
  sbsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.data.opcode),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  sbsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_chan.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

  assign out_chan.data = out_item;

endmodule

### sim/sixteen_bit_stack_machine_test.sv
// Self-checking testbench for the sixteen-bit stack machine: programs, runs and checks results.
module sixteen_bit_stack_machine_test;
  import sbsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Input kind that the block ignores.
  localparam logic [1:0] LD_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 1500;
  localparam int IDLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [7:0] OPS [10] = '{OPC_HALT, OPC_PUSH, OPC_POP, OPC_XOR, OPC_MUL,
                                      OPC_INP, OPC_JZ, OPC_DUP, OPC_INC, OPC_JEMP};

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sbsm_in_if  in_chan ();
  sbsm_out_if out_chan ();

  sixteen_bit_stack_machine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan.sink),
    .out_chan  (out_chan.source)
  );

  // Shadow state of the machine.
  logic [7:0]  mem_model [MEM_DEPTH];
  logic [7:0]  chars_model [INPUT_DEPTH];
  logic [15:0] stack_model [STACK_DEPTH];
  logic [14:0] origin_model;
  logic [31:0] limit_model;

  out_item_t run_results [$];
  int errors;
  int items_sent;
  int burst_left;
  bit hold_req;
  int hold_left;
  int stall_mode;
  int stall_timer;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Executes one run on the shadow state and returns its result.
  function automatic out_item_t execute_run();
    out_item_t r;
    int unsigned pc, ip, imm, depth, cursor, steps;
    logic [7:0] op;
    logic [15:0] a, b, c;
    logic [2:0] st;
    r.halt_value = '0;
    pc = origin_model;
    depth = 0;
    cursor = 0;
    steps = 0;
    while (1) begin
      ip = pc;
      imm = 0;
      if (steps >= limit_model) begin st = ST_STEPS; break; end
      if (ip > 32'h7FFF) begin st = ST_ADDR; break; end
      op = mem_model[ip];
      steps++;
      if (op == OPC_HALT || op == OPC_PUSH || op == OPC_JZ || op == OPC_JEMP) begin
        if (ip + 2 > 32'h7FFF) begin st = ST_ADDR; break; end
        imm = {mem_model[ip+2], mem_model[ip+1]};
      end
      if (op == OPC_HALT) begin
        r.halt_value = imm[15:0];
        st = ST_HALT;
        break;
      end else if (op == OPC_PUSH) begin
        if (depth >= STACK_DEPTH) begin st = ST_OVER; break; end
        stack_model[depth] = imm[15:0];
        depth++;
        pc = ip + 3;
      end else if (op == OPC_POP) begin
        if (depth == 0) begin st = ST_UNDER; break; end
        depth--;
        pc = ip + 1;
      end else if (op == OPC_XOR || op == OPC_MUL) begin
        if (depth < 2) begin st = ST_UNDER; break; end
        a = stack_model[depth-1];
        b = stack_model[depth-2];
        depth--;
        stack_model[depth-1] = (op == OPC_XOR) ? (a ^ b) : 16'(a * b);
        pc = ip + 1;
      end else if (op == OPC_INP) begin
        // The cursor is checked before the stack.
        if (cursor >= INPUT_DEPTH) begin st = ST_INPUT; break; end
        c = {{8{chars_model[cursor][7]}}, chars_model[cursor]};
        cursor++;
        if (depth >= STACK_DEPTH) begin st = ST_OVER; break; end
        stack_model[depth] = c;
        depth++;
        pc = ip + 1;
      end else if (op == OPC_JZ) begin
        if (depth == 0) begin st = ST_UNDER; break; end
        depth--;
        if (stack_model[depth] == 16'd0) begin
          if (imm > 32'h7FFF) begin st = ST_ADDR; break; end
          pc = imm;
        end else begin
          pc = ip + 3;
        end
      end else if (op == OPC_DUP) begin
        if (depth == 0) begin st = ST_UNDER; break; end
        if (depth >= STACK_DEPTH) begin st = ST_OVER; break; end
        stack_model[depth] = stack_model[depth-1];
        depth++;
        pc = ip + 1;
      end else if (op == OPC_INC) begin
        if (depth == 0) begin st = ST_UNDER; break; end
        stack_model[depth-1] = stack_model[depth-1] + 16'd1;
        pc = ip + 1;
      end else if (op == OPC_JEMP) begin
        if (depth == 0) begin
          if (imm > 32'h7FFF) begin st = ST_ADDR; break; end
          pc = imm;
        end else begin
          pc = ip + 3;
        end
      end else begin
        st = ST_BADOP;
        break;
      end
    end
    r.status = st;
    r.final_address = pc[14:0];
    return r;
  endfunction

  // Offers one item in bursts with random gaps, then updates the shadow state.
  task automatic send(input in_item_t it, input bit typed, input out_item_t want);
    @(negedge clk);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    case (it.opcode)
      LD_PROG:  mem_model[it.address] = it.data_byte;
      LD_INPUT: chars_model[it.input_index] = it.data_byte;
      LD_RUN: begin
        out_item_t got;
        got = execute_run();
        run_results.push_back(typed ? want : got);
      end
      default: ;
    endcase
  endtask

  task automatic load(input logic [1:0] kind, input int unsigned addr, input int unsigned idx,
                      input int unsigned data);
    in_item_t it;
    it.opcode = kind;
    it.address = addr[14:0];
    it.input_index = idx[4:0];
    it.data_byte = data[7:0];
    send(it, 1'b0, '0);
  endtask

  // Waits for all results, lets the block settle, then writes both registers.
  task automatic configure(input logic [14:0] org, input logic [31:0] lim);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (run_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ORIGIN;
    cfg_wdata <= {17'd0, org};
    @(negedge clk);
    cfg_index <= CFG_STEPS;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    origin_model = org;
    limit_model = lim;
    burst_left = 0;
  endtask

  function automatic int unsigned pick_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h7FFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Writes a random program at the origin, some input characters and noise, then runs it.
  // With forward_only set, jumps go only to later instruction starts, so every run ends.
  task automatic program_and_run(input bit forward_only);
    logic [7:0] ops [$];
    int unsigned starts [$];
    int unsigned at, imm, n, sel, k;
    sel = $urandom_range(0, 9);
    at = origin_model;
    if (sel == 0) begin
      // Growing loop that runs until a stack overflow, if no step limit or address bound ends it first.
      ops = '{OPC_PUSH, 8'd0, 8'd0, OPC_DUP, OPC_PUSH, 8'd0, 8'd0, OPC_JZ, 8'd0, 8'd0};
      imm = origin_model + 3;
      ops[8] = imm[7:0];
      ops[9] = imm[15:8];
      foreach (ops[i]) load(LD_PROG, at + i, 0, ops[i]);
    end else if (sel == 1) begin
      // Reads past the end of the input buffer.
      for (int i = 0; i < INPUT_DEPTH + 2; i++) load(LD_PROG, at + i, 0, OPC_INP);
      load(LD_PROG, at + INPUT_DEPTH + 2, 0, OPC_HALT);
    end else begin
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 19);
        ops.push_back((k < 18) ? OPS[k % 10] : 8'($urandom_range(0, 255)));
      end
      ops.push_back(OPC_HALT);
      foreach (ops[i]) begin
        starts.push_back(at);
        at += (ops[i] == OPC_HALT || ops[i] == OPC_PUSH || ops[i] == OPC_JZ ||
               ops[i] == OPC_JEMP) ? 3 : 1;
      end
      foreach (ops[i]) begin
        load(LD_PROG, starts[i], 0, ops[i]);
        if (starts[i] + 1 != at && (ops[i] == OPC_HALT || ops[i] == OPC_PUSH ||
            ops[i] == OPC_JZ || ops[i] == OPC_JEMP)) begin
          imm = pick_word();
          if (ops[i] == OPC_JZ || ops[i] == OPC_JEMP) begin
            if (forward_only) begin
              imm = (i + 1 < ops.size()) ? starts[$urandom_range(i + 1, ops.size() - 1)]
                                         : starts[i];
              if (i + 1 >= ops.size()) imm = 16'h8000;
            end else if ($urandom_range(0, 4) != 0) begin
              imm = starts[$urandom_range(0, ops.size() - 1)];
            end
          end
          load(LD_PROG, starts[i] + 1, 0, imm[7:0]);
          load(LD_PROG, starts[i] + 2, 0, imm[15:8]);
        end
      end
    end
    repeat ($urandom_range(0, 4))
      load(LD_INPUT, 0, $urandom_range(0, INPUT_DEPTH - 1), $urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0)
      load(LD_UNUSED, $urandom_range(0, 16'h7FFF), $urandom_range(0, 31), $urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0)
      load(LD_PROG, $urandom_range(0, 16'h5FFF), 0, $urandom_range(0, 255));
    load(LD_RUN, $urandom_range(0, 16'h7FFF), $urandom_range(0, 31), $urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) load(LD_RUN, 0, 0, 0);
  endtask

  // Receiver: changes its stall pattern now and then, and holds off once on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_timer = $urandom_range(50, 400);
      end
      stall_timer--;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 3) != 0);
          default: out_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compares each result with the oldest waiting expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (run_results.size() == 0) begin
        report($sformatf("unexpected result %h", out_chan.data));
      end else begin
        out_item_t want;
        want = run_results.pop_front();
        if (out_chan.data.halt_value !== want.halt_value)
          report($sformatf("halt_value %0d, wanted %0d", out_chan.data.halt_value,
                           want.halt_value));
        if (out_chan.data.status !== want.status)
          report($sformatf("status %0d, wanted %0d", out_chan.data.status, want.status));
        if (out_chan.data.final_address !== want.final_address)
          report($sformatf("final_address %h, wanted %h", out_chan.data.final_address,
                           want.final_address));
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("sixteen_bit_stack_machine test failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    int phase_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_mode = 0;
    stall_timer = 0;
    idle_cycles = 0;
    foreach (mem_model[i]) mem_model[i] = 8'd0;
    foreach (chars_model[i]) chars_model[i] = 8'd0;
    foreach (stack_model[i]) stack_model[i] = 16'd0;
    origin_model = ORIGIN_RST;
    limit_model = STEPS_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset configuration.
    rows = '{
      '{'{LD_RUN, 15'h0, 5'd0, 8'h0}, 1'b1, '{16'sd0, ST_BADOP, 15'h3000}},
      '{'{LD_INPUT, 15'h0, 5'd0, 8'h80}, 1'b0, '0},
      '{'{LD_PROG, 15'h3000, 5'd0, OPC_INP}, 1'b0, '0},
      '{'{LD_PROG, 15'h3001, 5'd0, OPC_DUP}, 1'b0, '0},
      '{'{LD_PROG, 15'h3002, 5'd0, OPC_MUL}, 1'b0, '0},
      '{'{LD_PROG, 15'h3003, 5'd0, OPC_INC}, 1'b0, '0},
      '{'{LD_PROG, 15'h3004, 5'd0, OPC_POP}, 1'b0, '0},
      '{'{LD_PROG, 15'h3005, 5'd0, OPC_HALT}, 1'b0, '0},
      '{'{LD_PROG, 15'h3006, 5'd0, 8'h00}, 1'b0, '0},
      '{'{LD_PROG, 15'h3007, 5'd0, 8'h80}, 1'b0, '0},
      '{'{LD_RUN, 15'h7FFF, 5'd31, 8'hFF}, 1'b1, '{-16'sd32768, ST_HALT, 15'h3005}},
      '{'{LD_PROG, 15'h3004, 5'd0, OPC_XOR}, 1'b0, '0},
      '{'{LD_RUN, 15'h0, 5'd0, 8'h0}, 1'b1, '{16'sd0, ST_UNDER, 15'h3004}},
      '{'{LD_UNUSED, 15'h7FFF, 5'd31, 8'hFF}, 1'b0, '0},
      '{'{LD_PROG, 15'h7FFF, 5'd31, 8'hFF}, 1'b0, '0},
      '{'{LD_INPUT, 15'h7FFF, 5'd31, 8'hFF}, 1'b0, '0},
      '{'{LD_PROG, 15'h3004, 5'd0, OPC_PUSH}, 1'b0, '0},
      '{'{LD_RUN, 15'h0, 5'd0, 8'h0}, 1'b0, '0}
    };
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

    // Extremes of the origin register, with small step limits.
    configure(15'h0000, 32'd1);
    repeat (4) program_and_run(1'b0);
    configure(15'h7FFF, 32'd50);
    repeat (4) program_and_run(1'b0);

    // Random phases with varied origin and step limit.
    for (int p = 0; items_sent < TOTAL_ITEMS - 200; p++) begin
      configure(($urandom_range(0, 7) == 0) ? 15'h7FF0 : 15'($urandom_range(0, 16'h3FFF)),
                ($urandom_range(0, 5) == 0) ? 32'd1 : 32'($urandom_range(1, 2000)));
      if (p == 1) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < 150) program_and_run(1'b0);
    end

    // Largest step limit on a fresh region, with programs that always end.
    configure(15'h6000, 32'hFFFF_FFFF);
    while (items_sent < TOTAL_ITEMS) program_and_run(1'b1);

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (run_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("sixteen_bit_stack_machine test passed");
    end else begin
      $display("sixteen_bit_stack_machine test failed");
    end
    $finish;
  end
endmodule

### sixteen_bit_stack_machine.f
hdl/sbsm_pkg.sv
hdl/sbsm_in_if.sv
hdl/sbsm_out_if.sv
hdl/sbsm_ctrl.sv
hdl/sbsm_dp.sv
hdl/sixteen_bit_stack_machine.sv
sim/sixteen_bit_stack_machine_test.sv
